// File: design/atilt_pkg.sv
// ----------------------------------------------------------------------------
// atilt_pkg
// Shared widths, register indexes, arctangent table and controller commands.
// ----------------------------------------------------------------------------
package atilt_pkg;

  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 8;

  // port widths
  localparam int IN_W      = 16;
  localparam int OUT_W     = 18;
  localparam int OFF_W     = 17;
  localparam int WGT_W     = 9;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_OFFSET   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_OFFSET  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_WEIGHT = 2'd2;

  localparam logic [WGT_W-1:0] WEIGHT_RESET = 9'd102;
  localparam logic [WGT_W-1:0] WEIGHT_FULL  = 9'd256;

  // datapath widths
  localparam int ACC_FRAC    = 20;  // angle accumulator, degrees in Q20
  localparam int VEC_W       = 36;  // CORDIC vector incl. gain growth
  localparam int ANG_W       = 30;
  localparam int SQ_W        = 32;
  localparam int ROOT_W      = 32;
  localparam int STEP_W      = 5;
  localparam int TAB_W       = 26;
  localparam int SQRT_CYCLES = 16;  // two root bits per cycle

  localparam logic signed [ANG_W-1:0] DEG180_Q20 = ANG_W'(180 * 1048576);

  // atan(2^-i) in degrees, Q20
  function automatic logic [TAB_W-1:0] atan_q20(input logic [STEP_W-1:0] idx);
    logic [TAB_W-1:0] v;
    unique case (idx)
      5'd0:    v = 26'd47185920;
      5'd1:    v = 26'd27855475;
      5'd2:    v = 26'd14718068;
      5'd3:    v = 26'd7471121;
      5'd4:    v = 26'd3750058;
      5'd5:    v = 26'd1876857;
      5'd6:    v = 26'd938658;
      5'd7:    v = 26'd469357;
      5'd8:    v = 26'd234682;
      5'd9:    v = 26'd117342;
      5'd10:   v = 26'd58671;
      5'd11:   v = 26'd29335;
      5'd12:   v = 26'd14668;
      5'd13:   v = 26'd7334;
      5'd14:   v = 26'd3667;
      5'd15:   v = 26'd1833;
      5'd16:   v = 26'd917;
      5'd17:   v = 26'd458;
      5'd18:   v = 26'd229;
      5'd19:   v = 26'd115;
      5'd20:   v = 26'd57;
      5'd21:   v = 26'd29;
      5'd22:   v = 26'd14;
      5'd23:   v = 26'd7;
      default: v = '0;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic              load;         // capture input word
    logic              square;       // y*y, z*z
    logic              start;        // start root and roll rotation
    logic              sqrt_en;
    logic              cordic_en;
    logic              pitch_start;  // save roll, start pitch rotation
    logic              scale;
    logic              diff;
    logic              mult;
    logic              update;       // filter state / output update
    logic [STEP_W-1:0] step;
  } atilt_cmd_t;

endpackage

// File: design/accel_tilt_estimator.sv
// ----------------------------------------------------------------------------
// accel_tilt_estimator
// Roll and pitch from a three-axis accelerometer word, offset and smoothed.
// ----------------------------------------------------------------------------
// One word is processed at a time: a new word is accepted only in the idle state,
// after the previous word's result has been written to the output register.
// The root unit runs beside the roll rotation, then the pitch rotation
// follows, on one shared CORDIC stage.
// Reset clears the filter state to zero, offsets to zero and weight to 102.
module accel_tilt_estimator import atilt_pkg::*; #(
  parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [IN_W-1:0]  accel_x_i,
  input  logic signed [IN_W-1:0]  accel_y_i,
  input  logic signed [IN_W-1:0]  accel_z_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [OUT_W-1:0] roll_angle_o,
  output logic signed [OUT_W-1:0] pitch_angle_o
);

  logic signed [OFF_W-1:0] roll_off_q, pitch_off_q;
  logic [WGT_W-1:0]        weight_q;
  atilt_cmd_t              cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_off_q  <= '0;
      pitch_off_q <= '0;
      weight_q    <= WEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ROLL_OFFSET:   roll_off_q  <= cfg_wdata_i[OFF_W-1:0];
        REG_PITCH_OFFSET:  pitch_off_q <= cfg_wdata_i[OFF_W-1:0];
        REG_SMOOTH_WEIGHT: weight_q    <= cfg_wdata_i[WGT_W-1:0];
        default: ;
      endcase
    end
  end

  atilt_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  atilt_dp #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .accel_x_i     (accel_x_i),
    .accel_y_i     (accel_y_i),
    .accel_z_i     (accel_z_i),
    .roll_off_i    (roll_off_q),
    .pitch_off_i   (pitch_off_q),
    .weight_i      (weight_q),
    .roll_angle_o  (roll_angle_o),
    .pitch_angle_o (pitch_angle_o)
  );

endmodule

// File: design/atilt_sqrt.sv
// ----------------------------------------------------------------------------
// atilt_sqrt
// Digit-by-digit floor square root of (sum << 32), two root bits per cycle while en_i is high.
// ----------------------------------------------------------------------------
module atilt_sqrt import atilt_pkg::*; (
  input  logic              clk_i,
  input  logic              init_i,
  input  logic [SQ_W-1:0]   sum_i,
  input  logic              en_i,
  output logic [ROOT_W-1:0] root_o
);

  localparam int REM_W = ROOT_W + 2;

  function automatic logic [REM_W+ROOT_W-1:0] sqrt_digit(
    input logic [REM_W-1:0]  rem,
    input logic [ROOT_W-1:0] root,
    input logic [1:0]        pair
  );
    logic [REM_W+1:0] cand;
    logic [REM_W+2:0] trial;
    cand  = {rem, pair};
    trial = {1'b0, cand} - (REM_W+3)'({root, 2'b01});
    if (!trial[REM_W+2]) begin
      return {trial[REM_W-1:0], root[ROOT_W-2:0], 1'b1};
    end
    return {cand[REM_W-1:0], root[ROOT_W-2:0], 1'b0};
  endfunction

  logic [SQ_W-1:0]         rad_q, rad_d;
  logic [REM_W-1:0]        rem_q, rem_d;
  logic [ROOT_W-1:0]       root_q, root_d;
  logic [REM_W+ROOT_W-1:0] s1, s2;

  always_comb begin
    s1 = sqrt_digit(rem_q, root_q, rad_q[SQ_W-1 -: 2]);
    s2 = sqrt_digit(s1[REM_W+ROOT_W-1:ROOT_W], s1[ROOT_W-1:0], rad_q[SQ_W-3 -: 2]);
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (init_i) begin
      rad_d  = sum_i;
      rem_d  = '0;
      root_d = '0;
    end else if (en_i) begin
      // radicand low half is zero, shift zeros in
      rad_d  = {rad_q[SQ_W-5:0], 4'b0000};
      rem_d  = s2[REM_W+ROOT_W-1:ROOT_W];
      root_d = s2[ROOT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o = root_q;

endmodule

// File: design/atilt_cordic.sv
// ----------------------------------------------------------------------------
// atilt_cordic
// Vectoring CORDIC, one micro-rotation per cycle while en_i is high, angle in Q20 degrees.
// ----------------------------------------------------------------------------
module atilt_cordic import atilt_pkg::*; (
  input  logic                    clk_i,
  input  logic                    init_i,
  input  logic signed [VEC_W-1:0] x0_i,
  input  logic signed [VEC_W-1:0] y0_i,
  input  logic signed [ANG_W-1:0] ang0_i,
  input  logic                    en_i,
  input  logic [STEP_W-1:0]       step_i,
  output logic signed [ANG_W-1:0] ang_o
);

  logic signed [VEC_W-1:0] x_q, x_d, y_q, y_d, dx, dy;
  logic signed [ANG_W-1:0] ang_q, ang_d, da;

  always_comb begin
    dx    = y_q >>> step_i;
    dy    = x_q >>> step_i;
    da    = $signed(ANG_W'(atan_q20(step_i)));
    x_d   = x_q;
    y_d   = y_q;
    ang_d = ang_q;
    if (init_i) begin
      x_d   = x0_i;
      y_d   = y0_i;
      ang_d = ang0_i;
    end else if (en_i) begin
      if (y_q > 0) begin
        x_d   = x_q + dx;
        y_d   = y_q - dy;
        ang_d = ang_q + da;
      end else begin
        x_d   = x_q - dx;
        y_d   = y_q + dy;
        ang_d = ang_q - da;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    ang_q <= ang_d;
  end

  assign ang_o = ang_q;

endmodule

// File: design/atilt_dp.sv
// ----------------------------------------------------------------------------
// atilt_dp
// Tilt datapath: squares, root, shared CORDIC, scaling and smoothing filter.
// ----------------------------------------------------------------------------
module atilt_dp import atilt_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  atilt_cmd_t              cmd_i,
  input  logic signed [IN_W-1:0]  accel_x_i,
  input  logic signed [IN_W-1:0]  accel_y_i,
  input  logic signed [IN_W-1:0]  accel_z_i,
  input  logic signed [OFF_W-1:0] roll_off_i,
  input  logic signed [OFF_W-1:0] pitch_off_i,
  input  logic [WGT_W-1:0]        weight_i,
  output logic signed [OUT_W-1:0] roll_angle_o,
  output logic signed [OUT_W-1:0] pitch_angle_o
);

  localparam int SH     = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam int A_W    = ANGLE_FRAC_BITS + 9;
  localparam int D_W    = (A_W > OFF_W ? A_W : OFF_W) + 1;
  localparam int DIFF_W = OUT_W + 1;
  localparam int PROD_W = DIFF_W + WGT_W + 1;

  localparam logic signed [ANG_W-1:0]  HALF_LSB   = ANG_W'(1 << (SH - 1));
  localparam logic signed [ANG_W-1:0]  ANGLE_LIM  = ANG_W'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(128);

  // Q20 to output scale, round half up, clamp to +-180 degrees
  function automatic logic signed [A_W-1:0] scale_angle(input logic signed [ANG_W-1:0] q);
    logic signed [ANG_W-1:0] r;
    r = (q + HALF_LSB) >>> SH;
    if (r > ANGLE_LIM) begin
      r = ANGLE_LIM;
    end else if (r < -ANGLE_LIM) begin
      r = -ANGLE_LIM;
    end
    return r[A_W-1:0];
  endfunction

  // saturate to the output range
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [D_W-1:0] d);
    if ((&d[D_W-1:OUT_W-1]) || !(|d[D_W-1:OUT_W-1])) begin
      return d[OUT_W-1:0];
    end
    return d[D_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
  endfunction

  logic signed [IN_W-1:0]   x_q, y_q, z_q;
  logic                     roll_zero_q, all_zero_q;
  logic [SQ_W-1:0]          yy_q, zz_q;
  logic [ROOT_W-1:0]        mag;
  logic signed [ANG_W-1:0]  cordic_ang, roll_q20_q;
  logic signed [VEC_W-1:0]  xe, ye, ze, roll_x0, roll_y0, pitch_x0, pitch_y0;
  logic signed [VEC_W-1:0]  cx0, cy0;
  logic signed [ANG_W-1:0]  roll_a0, ca0;
  logic signed [A_W-1:0]    a_roll_q, a_pitch_q;
  logic signed [DIFF_W-1:0] diff_roll_q, diff_pitch_q;
  logic signed [PROD_W-1:0] prod_roll_q, prod_pitch_q, rnd_roll, rnd_pitch;
  logic [WGT_W-1:0]         w_sat;
  logic signed [OUT_W-1:0]  s_roll_q, s_pitch_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q         <= accel_x_i;
      y_q         <= accel_y_i;
      z_q         <= accel_z_i;
      roll_zero_q <= (accel_y_i == '0) && (accel_z_i == '0);
      all_zero_q  <= (accel_x_i == '0) && (accel_y_i == '0) && (accel_z_i == '0);
    end
    if (cmd_i.square) begin
      yy_q <= SQ_W'(y_q * y_q);
      zz_q <= SQ_W'(z_q * z_q);
    end
  end

  atilt_sqrt u_sqrt (
    .clk_i  (clk_i),
    .init_i (cmd_i.start),
    .sum_i  (yy_q + zz_q),
    .en_i   (cmd_i.sqrt_en),
    .root_o (mag)
  );

  // roll with negative z is folded by 180 degrees
  always_comb begin
    xe       = VEC_W'(x_q);
    ye       = VEC_W'(y_q);
    ze       = VEC_W'(z_q);
    roll_x0  = (z_q[IN_W-1] ? -ze : ze) <<< 16;
    roll_y0  = (z_q[IN_W-1] ? -ye : ye) <<< 16;
    roll_a0  = !z_q[IN_W-1] ? '0 : (!y_q[IN_W-1] ? DEG180_Q20 : -DEG180_Q20);
    pitch_x0 = VEC_W'({1'b0, mag});
    pitch_y0 = (-xe) <<< 16;
    cx0      = cmd_i.pitch_start ? pitch_x0 : roll_x0;
    cy0      = cmd_i.pitch_start ? pitch_y0 : roll_y0;
    ca0      = cmd_i.pitch_start ? '0 : roll_a0;
  end

  atilt_cordic u_cordic (
    .clk_i  (clk_i),
    .init_i (cmd_i.start | cmd_i.pitch_start),
    .x0_i   (cx0),
    .y0_i   (cy0),
    .ang0_i (ca0),
    .en_i   (cmd_i.cordic_en),
    .step_i (cmd_i.step),
    .ang_o  (cordic_ang)
  );

  assign w_sat     = (weight_i > WEIGHT_FULL) ? WEIGHT_FULL : weight_i;
  assign rnd_roll  = (prod_roll_q + ROUND_HALF) >>> 8;
  assign rnd_pitch = (prod_pitch_q + ROUND_HALF) >>> 8;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pitch_start) begin
      roll_q20_q <= roll_zero_q ? '0 : cordic_ang;
    end
    if (cmd_i.scale) begin
      a_roll_q  <= scale_angle(roll_q20_q);
      a_pitch_q <= scale_angle(all_zero_q ? '0 : cordic_ang);
    end
    if (cmd_i.diff) begin
      diff_roll_q  <= DIFF_W'(sat_out(D_W'(a_roll_q) - D_W'(roll_off_i)))
                      - DIFF_W'(s_roll_q);
      diff_pitch_q <= DIFF_W'(sat_out(D_W'(a_pitch_q) - D_W'(pitch_off_i)))
                      - DIFF_W'(s_pitch_q);
    end
    if (cmd_i.mult) begin
      prod_roll_q  <= $signed({1'b0, w_sat}) * diff_roll_q;
      prod_pitch_q <= $signed({1'b0, w_sat}) * diff_pitch_q;
    end
  end

  // filter state doubles as the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_roll_q  <= '0;
      s_pitch_q <= '0;
    end else if (cmd_i.update) begin
      s_roll_q  <= s_roll_q + rnd_roll[OUT_W-1:0];
      s_pitch_q <= s_pitch_q + rnd_pitch[OUT_W-1:0];
    end
  end

  assign roll_angle_o  = s_roll_q;
  assign pitch_angle_o = s_pitch_q;

endmodule

// File: design/atilt_ctrl.sv
// ----------------------------------------------------------------------------
// atilt_ctrl
// Sequencer: steps the datapath through root, two rotations and the filter.
// ----------------------------------------------------------------------------
module atilt_ctrl import atilt_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output atilt_cmd_t cmd_o
);

  localparam int ROLL_CYC = (SQRT_CYCLES > CORDIC_STEPS) ? SQRT_CYCLES : CORDIC_STEPS;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_ROLL,
    ST_PITCH_INIT,
    ST_PITCH,
    ST_SCALE,
    ST_DIFF,
    ST_MULT,
    ST_UPDATE
  } state_e;

  state_e            state_q;
  logic [STEP_W-1:0] cnt_q;
  logic              out_valid_q;
  logic              slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o      = '0;
    cmd_o.step = cnt_q;
    unique case (state_q)
      ST_IDLE:       cmd_o.load        = in_valid_i;
      ST_SQUARE:     cmd_o.square      = 1'b1;
      ST_SUM:        cmd_o.start       = 1'b1;
      ST_ROLL: begin
        cmd_o.sqrt_en   = (cnt_q < STEP_W'(SQRT_CYCLES));
        cmd_o.cordic_en = (cnt_q < STEP_W'(CORDIC_STEPS));
      end
      ST_PITCH_INIT: cmd_o.pitch_start = 1'b1;
      ST_PITCH:      cmd_o.cordic_en   = 1'b1;
      ST_SCALE:      cmd_o.scale       = 1'b1;
      ST_DIFF:       cmd_o.diff        = 1'b1;
      ST_MULT:       cmd_o.mult        = 1'b1;
      ST_UPDATE:     cmd_o.update      = slot_free;
      default:       cmd_o             = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == ST_UPDATE) && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_SQUARE;
          end
        end
        ST_SQUARE: state_q <= ST_SUM;
        ST_SUM: begin
          state_q <= ST_ROLL;
          cnt_q   <= '0;
        end
        ST_ROLL: begin
          if (cnt_q == STEP_W'(ROLL_CYC - 1)) begin
            state_q <= ST_PITCH_INIT;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_PITCH_INIT: state_q <= ST_PITCH;
        ST_PITCH: begin
          if (cnt_q == STEP_W'(CORDIC_STEPS - 1)) begin
            state_q <= ST_SCALE;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_SCALE: state_q <= ST_DIFF;
        ST_DIFF:  state_q <= ST_MULT;
        ST_MULT:  state_q <= ST_UPDATE;
        ST_UPDATE: begin
          // hold the new word until the previous one is taken
          if (slot_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: sim/accel_tilt_estimator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_tilt_estimator_test
// Drives accelerometer words through the tilt estimator and checks every
// roll/pitch word against a behavioral predictor: vectoring arctangent, exact
// integer root, offset trim and exponential smoothing. A directed table runs
// first, then random phases under several register settings, with random
// input gaps and output back-pressure.
// ----------------------------------------------------------------------------
module accel_tilt_estimator_test;
  import atilt_pkg::*;

  localparam int    ATAN_LEN    = 24;
  localparam int    ROTATIONS   = (CORDIC_STEPS_DEF < ATAN_LEN) ? CORDIC_STEPS_DEF : ATAN_LEN;
  localparam int    DROP_BITS   = ACC_FRAC - ANGLE_FRAC_BITS_DEF;
  localparam longint HALF_TURN  = 64'sd180 * 64'sd1048576;
  localparam longint ANGLE_LIM  = 64'sd180 <<< ANGLE_FRAC_BITS_DEF;
  localparam longint TILT_MAX   = 64'sd131071;
  localparam longint TILT_MIN   = -64'sd131072;
  localparam int    RAND_WORDS  = 160;
  localparam int    NUM_PHASES  = 6;

  // atan(2^-i) in degrees, Q20
  localparam longint ATAN_Q20 [ATAN_LEN] = '{
    64'sd47185920, 64'sd27855475, 64'sd14718068, 64'sd7471121, 64'sd3750058,
    64'sd1876857, 64'sd938658, 64'sd469357, 64'sd234682, 64'sd117342,
    64'sd58671, 64'sd29335, 64'sd14668, 64'sd7334, 64'sd3667, 64'sd1833,
    64'sd917, 64'sd458, 64'sd229, 64'sd115, 64'sd57, 64'sd29, 64'sd14, 64'sd7
  };

  typedef struct {
    logic signed [OUT_W-1:0] roll;
    logic signed [OUT_W-1:0] pitch;
  } tilt_t;

  typedef struct packed {
    logic signed [IN_W-1:0]  x;
    logic signed [IN_W-1:0]  y;
    logic signed [IN_W-1:0]  z;
    logic                    typed;
    logic signed [OUT_W-1:0] roll;
    logic signed [OUT_W-1:0] pitch;
  } tilt_row_t;

  localparam int NUM_ROWS = 23;
  // typed results only where the filter state is still zero
  localparam tilt_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{16'sd0, 16'sd0, 16'sd0, 1'b1, 18'sd0, 18'sd0},
    '{16'sd0, 16'sd0, 16'sd0, 1'b1, 18'sd0, 18'sd0},
    '{16'sd0, 16'sd0, 16'sd16384, 1'b0, 18'sd0, 18'sd0},
    '{16'sd0, 16'sd0, -16'sd16384, 1'b0, 18'sd0, 18'sd0},
    '{16'sd0, 16'sd16384, 16'sd0, 1'b0, 18'sd0, 18'sd0},
    '{16'sd0, -16'sd16384, 16'sd0, 1'b0, 18'sd0, 18'sd0},
    '{16'sh7fff, 16'sd0, 16'sd0, 1'b0, 18'sd0, 18'sd0},
    '{16'sh8000, 16'sd0, 16'sd0, 1'b0, 18'sd0, 18'sd0},
    '{16'sd0, 16'sd0, 16'sh8000, 1'b0, 18'sd0, 18'sd0},
    '{16'sd0, 16'sd0, 16'sh7fff, 1'b0, 18'sd0, 18'sd0},
    '{16'sd0, 16'sh7fff, 16'sd0, 1'b0, 18'sd0, 18'sd0},
    '{16'sd0, 16'sh8000, 16'sd0, 1'b0, 18'sd0, 18'sd0},
    '{16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, 18'sd0, 18'sd0},
    '{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 18'sd0, 18'sd0},
    '{16'sh8000, 16'sh7fff, 16'sh8000, 1'b0, 18'sd0, 18'sd0},
    '{16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0, 18'sd0, 18'sd0},
    '{16'sd1, 16'sd0, -16'sd1, 1'b0, 18'sd0, 18'sd0},
    '{-16'sd1, 16'sd1, -16'sd1, 1'b0, 18'sd0, 18'sd0},
    '{16'sd100, -16'sd1, -16'sd5000, 1'b0, 18'sd0, 18'sd0},
    '{16'sd0, -16'sd1, 16'sh8000, 1'b0, 18'sd0, 18'sd0},
    '{16'sd0, 16'sd1, 16'sh8000, 1'b0, 18'sd0, 18'sd0},
    '{16'sd0, 16'sd0, 16'sd0, 1'b0, 18'sd0, 18'sd0},
    '{16'sd0, 16'sd0, 16'sd0, 1'b0, 18'sd0, 18'sd0}
  };

  // register settings per random phase: roll trim, pitch trim, weight
  // (the last two phases draw random trims, with a random then the reset weight)
  localparam int PHASE_ROLL  [4] = '{-46080, 65535, 0, -65536};
  localparam int PHASE_PITCH [4] = '{46080, -65536, 0, 65535};
  localparam int PHASE_W     [4] = '{256, 0, 511, 1};

  logic                    clk_i       = 1'b0;
  logic                    rst_n       = 1'b0;
  logic                    cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index   = '0;
  logic [CFG_W-1:0]        cfg_wdata   = '0;
  logic                    in_valid    = 1'b0;
  logic                    in_ready;
  logic signed [IN_W-1:0]  accel_x     = '0;
  logic signed [IN_W-1:0]  accel_y     = '0;
  logic signed [IN_W-1:0]  accel_z     = '0;
  logic                    out_valid;
  logic                    out_ready   = 1'b0;
  logic signed [OUT_W-1:0] roll_angle;
  logic signed [OUT_W-1:0] pitch_angle;

  // predictor state and register copies
  longint     roll_state  = 0;
  longint     pitch_state = 0;
  longint     roll_trim   = 0;
  longint     pitch_trim  = 0;
  logic [8:0] smooth_w    = WEIGHT_RESET;

  tilt_t      pending_tilt [$];
  int         mismatch_cnt = 0;
  int         burst_left   = 0;
  int         gap_len      = 0;
  logic [31:0] cyc         = '0;
  int         stall_mode   = 0;
  tilt_t      exp_word;

  accel_tilt_estimator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .accel_x_i     (accel_x),
    .accel_y_i     (accel_y),
    .accel_z_i     (accel_z),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .roll_angle_o  (roll_angle),
    .pitch_angle_o (pitch_angle)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // floor square root, two bits per pass
  function automatic longint unsigned root64(input longint unsigned n);
    longint unsigned rem;
    longint unsigned res;
    longint unsigned bitv;
    rem  = n;
    res  = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // vectoring rotation toward the x axis; vx must be >= 0, angle in Q20 deg
  function automatic longint rotate_to_axis(input longint vx, input longint vy,
                                            input longint base);
    longint ang;
    longint dx;
    longint dy;
    ang = base;
    for (int i = 0; i < ROTATIONS; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy > 0) begin
        vx  = vx + dx;
        vy  = vy - dy;
        ang = ang + ATAN_Q20[i];
      end else begin
        vx  = vx - dx;
        vy  = vy + dy;
        ang = ang - ATAN_Q20[i];
      end
    end
    return ang;
  endfunction

  function automatic longint to_deg256(input longint q20);
    longint a;
    a = (q20 + (64'sd1 <<< (DROP_BITS - 1))) >>> DROP_BITS;
    if (a > ANGLE_LIM) a = ANGLE_LIM;
    if (a < -ANGLE_LIM) a = -ANGLE_LIM;
    return a;
  endfunction

  function automatic longint smooth(input longint s, input longint a, input longint trim);
    longint d;
    longint w;
    d = a - trim;
    w = (smooth_w > WEIGHT_FULL) ? longint'(WEIGHT_FULL) : longint'(smooth_w);
    if (d > TILT_MAX) d = TILT_MAX;
    if (d < TILT_MIN) d = TILT_MIN;
    return s + ((w * (d - s) + 64'sd128) >>> 8);
  endfunction

  task automatic predict_tilt(input logic signed [IN_W-1:0] x, input logic signed [IN_W-1:0] y,
                              input logic signed [IN_W-1:0] z, output tilt_t res);
    longint ax;
    longint ay;
    longint az;
    longint mag;
    longint roll_q20;
    longint pitch_q20;
    longint unsigned sumsq;
    ax = x;
    ay = y;
    az = z;
    sumsq     = longint'(ay * ay + az * az);
    mag       = longint'(root64(sumsq << 32));
    roll_q20  = 0;
    pitch_q20 = 0;
    if (ay != 0 || az != 0) begin
      // fold the left half-plane by 180 degrees
      if (az < 0) begin
        roll_q20 = rotate_to_axis(-az * 65536, -ay * 65536, (ay >= 0) ? HALF_TURN : -HALF_TURN);
      end else begin
        roll_q20 = rotate_to_axis(az * 65536, ay * 65536, 0);
      end
    end
    if (ax != 0 || mag != 0) pitch_q20 = rotate_to_axis(mag, -ax * 65536, 0);
    roll_state  = smooth(roll_state, to_deg256(roll_q20), roll_trim);
    pitch_state = smooth(pitch_state, to_deg256(pitch_q20), pitch_trim);
    res.roll  = roll_state[OUT_W-1:0];
    res.pitch = pitch_state[OUT_W-1:0];
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    logic [CFG_W-1:0] v;
    v = CFG_W'(value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    case (idx)
      REG_ROLL_OFFSET:   roll_trim  = longint'($signed(v));
      REG_PITCH_OFFSET:  pitch_trim = longint'($signed(v));
      REG_SMOOTH_WEIGHT: smooth_w   = v[8:0];
      default: ;
    endcase
  endtask

  task automatic set_levels(input int roll_off, input int pitch_off, input int weight);
    write_reg(REG_ROLL_OFFSET, roll_off);
    write_reg(REG_PITCH_OFFSET, pitch_off);
    write_reg(REG_SMOOTH_WEIGHT, weight);
  endtask

  // hold input until every word in flight has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_tilt.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_word(input logic signed [IN_W-1:0] x, input logic signed [IN_W-1:0] y,
                           input logic signed [IN_W-1:0] z, input logic typed,
                           input logic signed [OUT_W-1:0] t_roll,
                           input logic signed [OUT_W-1:0] t_pitch);
    tilt_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap_len != 0) begin
        in_valid <= 1'b0;
        repeat (gap_len) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    accel_x  <= x;
    accel_y  <= y;
    accel_z  <= z;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    predict_tilt(x, y, z, res);
    if (typed) begin
      res.roll  = t_roll;
      res.pitch = t_pitch;
    end
    pending_tilt.push_back(res);
  endtask

  function automatic logic signed [IN_W-1:0] pick_axis();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 16'sh7fff;
      2:       return 16'sh8000;
      3:       return IN_W'($urandom_range(0, 32)) - 16'sd16;
      default: return IN_W'($urandom);
    endcase
  endfunction

  // receiver: back-pressure pattern is redrawn whenever the low eight bits of cyc are zero
  always @(posedge clk_i) begin
    cyc <= cyc + 32'd1;
    if (cyc[7:0] == 8'd0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= (cyc[2:0] == 3'd0);
      default: out_ready <= cyc[4];
    endcase
    if (rst_n && out_valid && out_ready) begin
      if (pending_tilt.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected word: roll %0d pitch %0d", roll_angle, pitch_angle);
      end else begin
        exp_word = pending_tilt.pop_front();
        if (roll_angle !== exp_word.roll || pitch_angle !== exp_word.pitch) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("tilt mismatch: roll exp %0d got %0d, pitch exp %0d got %0d",
                     exp_word.roll, roll_angle, exp_word.pitch, pitch_angle);
        end
      end
    end
  end

  initial begin
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
    logic signed [IN_W-1:0] z;
    int kind;
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // directed table at reset settings
    for (int r = 0; r < NUM_ROWS; r++) begin
      send_word(DIRECTED_ROWS[r].x, DIRECTED_ROWS[r].y, DIRECTED_ROWS[r].z,
                DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].roll, DIRECTED_ROWS[r].pitch);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      if (p < 4) begin
        set_levels(PHASE_ROLL[p], PHASE_PITCH[p], PHASE_W[p]);
      end else begin
        set_levels(int'($urandom_range(0, 92160)) - 46080,
                   int'($urandom_range(0, 92160)) - 46080,
                   (p == 4) ? int'($urandom_range(0, 511)) : int'(WEIGHT_RESET));
      end
      for (int n = 0; n < RAND_WORDS; n++) begin
        if (n == RAND_WORDS / 2) wait_drained();
        x = pick_axis();
        y = pick_axis();
        z = pick_axis();
        kind = $urandom_range(0, 15);
        // zero roll vector, and roll on the fold line
        if (kind == 0) begin
          y = '0;
          z = '0;
        end else if (kind == 1) begin
          y = '0;
        end
        send_word(x, y, z, 1'b0, '0, '0);
      end
    end

    wait_drained();
    repeat (60) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
